@@ hdl/gbts_pkg.sv @@
package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int PTR_W    = $clog2(CAPACITY + 1);

    localparam int MODE_W = 2;
    localparam int POS_W  = 13;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 2;

    // common width for comparing a request position against a gap pointer
    localparam int CMP_W = (PTR_W > POS_W) ? PTR_W : POS_W;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_FWD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ     = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd2;

    typedef struct packed {
        logic accept;
        logic step;
        logic edit;
        logic read;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic at_target;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/gbts_if.sv @@
interface gbts_req_if;
    logic                        valid;
    logic                        ready;
    logic [gbts_pkg::MODE_W-1:0] mode;
    logic [gbts_pkg::POS_W-1:0]  position;
    logic [gbts_pkg::CHAR_W-1:0] character;

    modport source (output valid, output mode, output position, output character,
                    input ready);
    modport sink   (input valid, input mode, input position, input character,
                    output ready);
endinterface

interface gbts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [gbts_pkg::POS_W-1:0]  new_position;
    logic [gbts_pkg::CHAR_W-1:0] read_char;
    logic [gbts_pkg::POS_W-1:0]  text_length;
    logic [gbts_pkg::STAT_W-1:0] status;

    modport source (output valid, output new_position, output read_char,
                    output text_length, output status, input ready);
    modport sink   (input valid, input new_position, input read_char,
                    input text_length, input status, output ready);
endinterface

@@ hdl/gbts_ctrl.sv @@
module gbts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  gbts_pkg::t_sts  i_sts,
    output gbts_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_EDIT = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.accept   = i_req_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = i_sts.is_read ? S_READ : S_MOVE;
                end
            end
            S_MOVE: begin
                // one byte crosses the gap per cycle until it sits at the target
                o_cmd.step = !i_sts.at_target;
                if (i_sts.at_target) begin
                    n_state = S_EDIT;
                end
            end
            S_EDIT: begin
                o_cmd.edit = 1'b1;
                n_state    = S_DONE;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/gbts_dp.sv @@
module gbts_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbts_pkg::t_cmd              i_cmd,
    output gbts_pkg::t_sts              o_sts,
    input  logic [gbts_pkg::MODE_W-1:0] i_mode,
    input  logic [gbts_pkg::POS_W-1:0]  i_position,
    input  logic [gbts_pkg::CHAR_W-1:0] i_character,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [gbts_pkg::POS_W-1:0]  o_new_position,
    output logic [gbts_pkg::CHAR_W-1:0] o_read_char,
    output logic [gbts_pkg::POS_W-1:0]  o_text_length,
    output logic [gbts_pkg::STAT_W-1:0] o_status
);

    localparam logic [gbts_pkg::PTR_W-1:0] CAP_PTR = gbts_pkg::PTR_W'(gbts_pkg::CAPACITY);
    localparam logic [gbts_pkg::PTR_W-1:0] ONE_PTR = gbts_pkg::PTR_W'(1);

    logic [gbts_pkg::CHAR_W-1:0] r_mem [gbts_pkg::CAPACITY];

    logic [gbts_pkg::PTR_W-1:0]  r_gb, n_gb;
    logic [gbts_pkg::PTR_W-1:0]  r_gf, n_gf;
    logic [gbts_pkg::MODE_W-1:0] r_mode;
    logic [gbts_pkg::POS_W-1:0]  r_pos;
    logic [gbts_pkg::PTR_W-1:0]  r_p;
    logic [gbts_pkg::CHAR_W-1:0] r_ch;
    logic                        r_read_ok;
    logic [gbts_pkg::PTR_W-1:0]  r_newpos, n_newpos;
    logic [gbts_pkg::STAT_W-1:0] r_status, n_status;

    logic                        r_wr_valid;
    logic [gbts_pkg::ADDR_W-1:0] r_wr_addr;
    logic [gbts_pkg::CHAR_W-1:0] r_rd_data;

    logic                        r_out_valid;
    logic [gbts_pkg::POS_W-1:0]  r_out_newpos;
    logic [gbts_pkg::CHAR_W-1:0] r_out_char;
    logic [gbts_pkg::POS_W-1:0]  r_out_len;
    logic [gbts_pkg::STAT_W-1:0] r_out_status;

    logic [gbts_pkg::PTR_W-1:0]  len;
    logic [gbts_pkg::CMP_W-1:0]  pos_x;
    logic [gbts_pkg::CMP_W-1:0]  len_x;
    logic [gbts_pkg::PTR_W-1:0]  clamp_p;
    logic                        move_left;
    logic [gbts_pkg::ADDR_W-1:0] step_rd_addr;
    logic [gbts_pkg::ADDR_W-1:0] step_wr_addr;
    logic [gbts_pkg::ADDR_W-1:0] phys_addr;
    logic [gbts_pkg::ADDR_W-1:0] rd_addr;
    logic                        rd_en;
    logic                        ins_we;
    logic                        mem_we;
    logic [gbts_pkg::ADDR_W-1:0] mem_wa;
    logic [gbts_pkg::CHAR_W-1:0] mem_wd;

    assign len     = CAP_PTR - (r_gf - r_gb);
    assign pos_x   = gbts_pkg::CMP_W'(i_position);
    assign len_x   = gbts_pkg::CMP_W'(len);
    assign clamp_p = (pos_x > len_x) ? len : gbts_pkg::PTR_W'(i_position);

    assign move_left    = (r_gb > r_p);
    assign step_rd_addr = move_left ? gbts_pkg::ADDR_W'(r_gb - ONE_PTR)
                                    : gbts_pkg::ADDR_W'(r_gf);
    assign step_wr_addr = move_left ? gbts_pkg::ADDR_W'(r_gf - ONE_PTR)
                                    : gbts_pkg::ADDR_W'(r_gb);
    assign phys_addr    = (gbts_pkg::CMP_W'(r_pos) < gbts_pkg::CMP_W'(r_gb))
                          ? gbts_pkg::ADDR_W'(r_pos)
                          : gbts_pkg::ADDR_W'(gbts_pkg::CMP_W'(r_pos)
                                              + gbts_pkg::CMP_W'(r_gf - r_gb));

    assign rd_en   = i_cmd.step || i_cmd.read;
    assign rd_addr = i_cmd.step ? step_rd_addr : phys_addr;

    assign o_sts.is_read   = (i_mode == gbts_pkg::MODE_READ);
    assign o_sts.at_target = (r_gb == r_p);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // gap pointers, cursor and status of the edit
    always_comb begin
        n_gb     = r_gb;
        n_gf     = r_gf;
        n_newpos = r_newpos;
        n_status = r_status;
        ins_we   = 1'b0;
        if (i_cmd.accept) begin
            n_newpos = clamp_p;
            n_status = (o_sts.is_read && !(pos_x < len_x)) ? gbts_pkg::STAT_PAST_END
                                                           : gbts_pkg::STAT_OK;
        end else if (i_cmd.step) begin
            n_gb = move_left ? r_gb - ONE_PTR : r_gb + ONE_PTR;
            n_gf = move_left ? r_gf - ONE_PTR : r_gf + ONE_PTR;
        end else if (i_cmd.edit) begin
            case (r_mode)
                gbts_pkg::MODE_INSERT: begin
                    if (r_gb < r_gf) begin
                        ins_we   = 1'b1;
                        n_gb     = r_gb + ONE_PTR;
                        n_newpos = r_p + ONE_PTR;
                    end else begin
                        n_status = gbts_pkg::STAT_FULL;
                    end
                end
                gbts_pkg::MODE_DEL_BACK: begin
                    if (r_gb != '0) begin
                        n_gb     = r_gb - ONE_PTR;
                        n_newpos = r_p - ONE_PTR;
                    end else begin
                        n_newpos = '0;
                    end
                end
                gbts_pkg::MODE_DEL_FWD: begin
                    if (r_gf < CAP_PTR) begin
                        n_gf = r_gf + ONE_PTR;
                    end
                end
                default: begin
                    n_gb = r_gb;
                end
            endcase
        end
    end

    // single write port: a pending shift write never meets an insert
    assign mem_we = r_wr_valid || ins_we;
    assign mem_wa = r_wr_valid ? r_wr_addr : gbts_pkg::ADDR_W'(r_gb);
    assign mem_wd = r_wr_valid ? r_rd_data : r_ch;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gb        <= '0;
            r_gf        <= CAP_PTR;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_gb       <= n_gb;
            r_gf       <= n_gf;
            r_wr_valid <= i_cmd.step;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_newpos <= n_newpos;
        r_status <= n_status;
        if (i_cmd.step) begin
            r_wr_addr <= step_wr_addr;
        end
        if (i_cmd.accept) begin
            r_mode    <= i_mode;
            r_pos     <= i_position;
            r_p       <= clamp_p;
            r_ch      <= i_character;
            r_read_ok <= (pos_x < len_x);
        end
        if (i_cmd.load_out) begin
            r_out_newpos <= gbts_pkg::POS_W'(r_newpos);
            r_out_char   <= (r_mode == gbts_pkg::MODE_READ && r_read_ok) ? r_rd_data : '0;
            r_out_len    <= gbts_pkg::POS_W'(len);
            r_out_status <= r_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_position = r_out_newpos;
    assign o_read_char    = r_out_char;
    assign o_text_length  = r_out_len;
    assign o_status       = r_out_status;

    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gb <= r_gf) && (r_gf <= CAP_PTR))
        else $error("gap pointers out of order");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr_valid && ins_we))
        else $error("shift write and insert collide");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_gf - r_gb) == $past(r_gf - r_gb))
        else $error("gap size changed during a move");

endmodule

@@ hdl/gap_buffer_text_store_top.sv @@
// Channel | Dir | Payload                                           | Handshake
// i_req   | in  | mode, position, character                         | valid/ready
// o_rsp   | out | new_position, read_char, text_length, status      | valid/ready
//
// An edit first moves the gap by d, the distance to the target (up to 4096):
// the byte store, with its single write port, moves one byte per cycle across
// the gap, with a read and a delayed write overlapped. A read never moves the gap.
// Reset (synchronous, low) empties the text; the store itself is not cleared.
// A finished result waits in the output register while the next request is taken.
// A stalled output holds only the final handoff; work on the next request continues.
module gap_buffer_text_store_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbts_req_if.sink    i_req,
    gbts_rsp_if.source  o_rsp
);

    gbts_pkg::t_cmd w_cmd;
    gbts_pkg::t_sts w_sts;
    logic           w_req_ready;

    // sequence each request: accept, move gap, edit or read, hand off
    gbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_req_ready;

    // byte store, gap pointers and output register
    gbts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_mode         (i_req.mode),
        .i_position     (i_req.position),
        .i_character    (i_req.character),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_new_position (o_rsp.new_position),
        .o_read_char    (o_rsp.read_char),
        .o_text_length  (o_rsp.text_length),
        .o_status       (o_rsp.status)
    );

endmodule
